/* sv/fla_pkg.sv */
// fla_pkg: shared types and constants of the free list allocator
// no dependencies
package fla_pkg;
	localparam int MaxRegions = 4096;
	localparam int IdxW = $clog2(MaxRegions);
	localparam int CntW = $clog2(MaxRegions + 1);

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StNoFit = 2'd1;
	localparam logic [1:0] StLost = 2'd2;

	localparam logic OpAlloc = 1'b0;
	localparam logic OpFree = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] region_addr;
		logic [31:0] region_size;
	} req_t;

	typedef struct packed {
		logic [31:0] alloc_addr;
		logic [1:0]  status;
		logic [31:0] free_total;
		logic [12:0] entry_count;
		logic [12:0] peak_count;
		logic [31:0] lost_count;
		logic [31:0] lost_bytes;
	} rsp_t;

	// one table entry: start and length side by side
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] length;
	} region_t;

	// memory port command from the sequencer
	typedef struct packed {
		logic            we;
		logic [IdxW-1:0] waddr;
		region_t         wdata;
		logic [IdxW-1:0] raddr;
	} mem_cmd_t;
endpackage

/* sv/free_list_allocator.sv */
// free_list_allocator: top level, sequencer around the region table
// depends on fla_pkg and fla_ram
//
// Usage: raise start with req while busy is low; the item is taken at that
// edge and busy rises. When the work is done, done pulses for one cycle with
// rsp valid, and busy falls at the end of that cycle. The next item can be
// taken in the cycle after done. The receiver cannot stall; rsp is valid
// only while done is high.
// Sequencing: the sequencer walks the table through the single read port of
// the region memory; each entry visited takes a read issue, then a data use.
// Allocate: scan to the first fit, then a shift down over the later entries
// when the region empties.
// Free: scan to the insert point, then a shift up over the later entries for
// an insert, or a shift down when the region merges with both neighbours.
// Items are handled one at a time; a new item is not taken while busy is high.
// Reset clears the entry count and all counters; memory contents need no
// clearing since only entries below the count are used.
module free_list_allocator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  fla_pkg::req_t    req,
	output logic             busy,
	output logic             done,
	output fla_pkg::rsp_t    rsp
);
	localparam int IW = fla_pkg::IdxW;
	localparam int CW = fla_pkg::CntW;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK,
		S_SHD_RD, S_SHD_WR, S_SHU_RD, S_SHU_WR, S_DONE
	} state_t;

	state_t state_q;
	fla_pkg::req_t req_q;
	logic [CW-1:0] count_q, peak_q, idx_q, pos_q;
	logic [31:0] total_q, lost_cnt_q, lost_bytes_q, grant_q;
	logic [1:0] status_q;
	logic prev_ok_q;
	fla_pkg::region_t prev_q;
	fla_pkg::mem_cmd_t cmd;
	fla_pkg::region_t rdata;

	fla_ram u_ram (.clk(clk), .cmd(cmd), .rdata(rdata));

	logic [31:0] prev_end, req_end;
	logic merge_prev, merge_next, is_free, fit, past_addr;
	assign prev_end = prev_q.start + prev_q.length;
	assign req_end = req_q.region_addr + req_q.region_size;
	assign merge_prev = prev_ok_q && (prev_end == req_q.region_addr);
	assign merge_next = (rdata.start == req_end);
	assign is_free = (req_q.opcode == fla_pkg::OpFree);
	assign fit = (rdata.length >= req_q.region_size);
	assign past_addr = (rdata.start > req_q.region_addr);

	// memory commands follow the state
	always_comb begin
		cmd = '0;
		cmd.raddr = idx_q[IW-1:0];
		cmd.waddr = idx_q[IW-1:0];
		case (state_q)
			S_SCAN_RD: begin
				// end of table on a free that touches the last region
				if (idx_q == count_q && is_free && merge_prev) begin
					cmd.we = 1'b1;
					cmd.waddr = IW'(idx_q - 1'b1);
					cmd.wdata.start = prev_q.start;
					cmd.wdata.length = prev_q.length + req_q.region_size;
				end
			end
			S_SCAN_CHK: begin
				if (!is_free) begin
					if (fit && rdata.length != req_q.region_size) begin
						cmd.we = 1'b1;
						cmd.wdata.start = rdata.start + req_q.region_size;
						cmd.wdata.length = rdata.length - req_q.region_size;
					end
				end else if (past_addr) begin
					if (merge_prev) begin
						cmd.we = 1'b1;
						cmd.waddr = IW'(idx_q - 1'b1);
						cmd.wdata.start = prev_q.start;
						cmd.wdata.length = prev_q.length + req_q.region_size
							+ (merge_next ? rdata.length : 32'd0);
					end else if (merge_next) begin
						cmd.we = 1'b1;
						cmd.wdata.start = req_q.region_addr;
						cmd.wdata.length = rdata.length + req_q.region_size;
					end
				end
			end
			S_SHD_WR: begin
				cmd.we = 1'b1;
				cmd.waddr = IW'(idx_q - 1'b1);
				cmd.wdata = rdata;
			end
			S_SHU_RD: begin
				if (idx_q == pos_q) begin
					cmd.we = 1'b1;
					cmd.wdata.start = req_q.region_addr;
					cmd.wdata.length = req_q.region_size;
				end else begin
					cmd.raddr = IW'(idx_q - 1'b1);
				end
			end
			S_SHU_WR: begin
				cmd.we = 1'b1;
				cmd.wdata = rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			count_q <= '0;
			peak_q <= '0;
			total_q <= '0;
			lost_cnt_q <= '0;
			lost_bytes_q <= '0;
			idx_q <= '0;
			pos_q <= '0;
			prev_q <= '0;
			prev_ok_q <= 1'b0;
			status_q <= fla_pkg::StOk;
			grant_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						idx_q <= '0;
						prev_ok_q <= 1'b0;
						grant_q <= '0;
						status_q <= fla_pkg::StOk;
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					if (idx_q == count_q) begin
						if (!is_free) begin
							status_q <= fla_pkg::StNoFit;
							state_q <= S_DONE;
						end else if (merge_prev) begin
							total_q <= total_q + req_q.region_size;
							state_q <= S_DONE;
						end else if (count_q == CW'(fla_pkg::MaxRegions)) begin
							status_q <= fla_pkg::StLost;
							lost_cnt_q <= lost_cnt_q + 32'd1;
							lost_bytes_q <= lost_bytes_q + req_q.region_size;
							state_q <= S_DONE;
						end else begin
							pos_q <= idx_q;
							idx_q <= count_q;
							count_q <= CW'(count_q + 1'b1);
							if (peak_q == count_q) peak_q <= CW'(count_q + 1'b1);
							total_q <= total_q + req_q.region_size;
							state_q <= S_SHU_RD;
						end
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (!is_free) begin
						if (fit) begin
							grant_q <= rdata.start;
							total_q <= total_q - req_q.region_size;
							if (rdata.length == req_q.region_size) begin
								count_q <= CW'(count_q - 1'b1);
								idx_q <= CW'(idx_q + 1'b1);
								state_q <= S_SHD_RD;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							idx_q <= CW'(idx_q + 1'b1);
							state_q <= S_SCAN_RD;
						end
					end else if (past_addr) begin
						if (merge_prev) begin
							total_q <= total_q + req_q.region_size;
							if (merge_next) begin
								count_q <= CW'(count_q - 1'b1);
								idx_q <= CW'(idx_q + 1'b1);
								state_q <= S_SHD_RD;
							end else begin
								state_q <= S_DONE;
							end
						end else if (merge_next) begin
							total_q <= total_q + req_q.region_size;
							state_q <= S_DONE;
						end else if (count_q == CW'(fla_pkg::MaxRegions)) begin
							status_q <= fla_pkg::StLost;
							lost_cnt_q <= lost_cnt_q + 32'd1;
							lost_bytes_q <= lost_bytes_q + req_q.region_size;
							state_q <= S_DONE;
						end else begin
							pos_q <= idx_q;
							idx_q <= count_q;
							count_q <= CW'(count_q + 1'b1);
							if (peak_q == count_q) peak_q <= CW'(count_q + 1'b1);
							total_q <= total_q + req_q.region_size;
							state_q <= S_SHU_RD;
						end
					end else begin
						prev_q <= rdata;
						prev_ok_q <= 1'b1;
						idx_q <= CW'(idx_q + 1'b1);
						state_q <= S_SCAN_RD;
					end
				end
				S_SHD_RD: begin
					// idx_q is the source slot, count_q already reduced
					if (idx_q > count_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHD_WR;
					end
				end
				S_SHD_WR: begin
					idx_q <= CW'(idx_q + 1'b1);
					state_q <= S_SHD_RD;
				end
				S_SHU_RD: begin
					// idx_q is the target slot, the new item lands at pos_q
					if (idx_q == pos_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SHU_WR;
					end
				end
				S_SHU_WR: begin
					idx_q <= CW'(idx_q - 1'b1);
					state_q <= S_SHU_RD;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	always_comb begin
		rsp.alloc_addr = grant_q;
		rsp.status = status_q;
		rsp.free_total = total_q;
		rsp.entry_count = 13'(count_q);
		rsp.peak_count = 13'(peak_q);
		rsp.lost_count = lost_cnt_q;
		rsp.lost_bytes = lost_bytes_q;
	end

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done);
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(fla_pkg::MaxRegions));
	a_peak: assert property (@(posedge clk) disable iff (!arst_n) peak_q >= count_q);
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.status <= fla_pkg::StLost);
endmodule

/* sv/fla_ram.sv */
// fla_ram: region table, one write and one registered read port
// depends on fla_pkg
module fla_ram (
	input  logic                clk,
	input  fla_pkg::mem_cmd_t   cmd,
	output fla_pkg::region_t    rdata
);
	fla_pkg::region_t mem [fla_pkg::MaxRegions];

	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem[cmd.waddr] <= cmd.wdata;
		end
		rdata <= mem[cmd.raddr];
	end
endmodule

/* sim/tb.sv */
// tb: self-checking bench for free_list_allocator, random and directed items
// depends on fla_pkg and the allocator rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	class alloc_board;
		logic [31:0] starts[$];
		logic [31:0] lens[$];
		logic [12:0] peak;
		logic [31:0] lost_n, lost_b, total;
		fla_pkg::rsp_t pending[$];
		int errors;
		int checked;

		function new();
			peak = 0; lost_n = 0; lost_b = 0; total = 0; errors = 0; checked = 0;
		endfunction

		// predict the result of one accepted item
		function void note_item(fla_pkg::req_t r);
			fla_pkg::rsp_t e;
			int pos;
			int k;
			e = '0;
			e.status = fla_pkg::StOk;
			if (r.opcode == fla_pkg::OpAlloc) begin
				e.status = fla_pkg::StNoFit;
				for (k = 0; k < starts.size(); k++) begin
					if (lens[k] >= r.region_size) begin
						e.alloc_addr = starts[k];
						e.status = fla_pkg::StOk;
						starts[k] = starts[k] + r.region_size;
						lens[k] = lens[k] - r.region_size;
						total = total - r.region_size;
						if (lens[k] == 0) begin
							starts.delete(k);
							lens.delete(k);
						end
						break;
					end
				end
			end else begin
				pos = 0;
				while (pos < starts.size() && starts[pos] <= r.region_addr) pos++;
				if (pos > 0 && starts[pos-1] + lens[pos-1] == r.region_addr) begin
					lens[pos-1] = lens[pos-1] + r.region_size;
					if (pos < starts.size() &&
					    r.region_addr + r.region_size == starts[pos]) begin
						lens[pos-1] = lens[pos-1] + lens[pos];
						starts.delete(pos);
						lens.delete(pos);
					end
					total = total + r.region_size;
				end else if (pos < starts.size() &&
				             r.region_addr + r.region_size == starts[pos]) begin
					starts[pos] = r.region_addr;
					lens[pos] = lens[pos] + r.region_size;
					total = total + r.region_size;
				end else if (starts.size() < fla_pkg::MaxRegions) begin
					starts.insert(pos, r.region_addr);
					lens.insert(pos, r.region_size);
					if (peak < starts.size()) peak = 13'(starts.size());
					total = total + r.region_size;
				end else begin
					lost_n = lost_n + 1;
					lost_b = lost_b + r.region_size;
					e.status = fla_pkg::StLost;
				end
			end
			e.free_total = total;
			e.entry_count = 13'(starts.size());
			e.peak_count = peak;
			e.lost_count = lost_n;
			e.lost_bytes = lost_b;
			pending.push_back(e);
		endfunction

		function void check_result(fla_pkg::rsp_t a);
			fla_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (a.alloc_addr !== e.alloc_addr) begin
				$error("alloc_addr exp %h got %h", e.alloc_addr, a.alloc_addr); errors++;
			end
			if (a.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, a.status); errors++;
			end
			if (a.free_total !== e.free_total) begin
				$error("free_total exp %h got %h", e.free_total, a.free_total); errors++;
			end
			if (a.entry_count !== e.entry_count) begin
				$error("entry_count exp %0d got %0d", e.entry_count, a.entry_count);
				errors++;
			end
			if (a.peak_count !== e.peak_count) begin
				$error("peak_count exp %0d got %0d", e.peak_count, a.peak_count); errors++;
			end
			if (a.lost_count !== e.lost_count) begin
				$error("lost_count exp %0d got %0d", e.lost_count, a.lost_count); errors++;
			end
			if (a.lost_bytes !== e.lost_bytes) begin
				$error("lost_bytes exp %h got %h", e.lost_bytes, a.lost_bytes); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	fla_pkg::req_t req = '0;
	logic busy, done;
	fla_pkg::rsp_t rsp;
	alloc_board board = new();
	int idle_pct = 0;
	int n_alloc = 0, n_free = 0;

	free_list_allocator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	always @(posedge clk) begin
		if (done) board.check_result(rsp);
	end

	// hand one item over and wait until it is taken
	task automatic send_item(logic op, logic [31:0] addr, logic [31:0] size);
		fla_pkg::req_t r;
		while ($urandom_range(99) < idle_pct) @(posedge clk);
		r.opcode = op;
		r.region_addr = addr;
		r.region_size = size;
		start <= 1;
		req <= r;
		do @(posedge clk); while (busy);
		board.note_item(r);
		if (op == fla_pkg::OpAlloc) n_alloc++; else n_free++;
		start <= 0;
		// let busy rise before the next look
		@(posedge clk);
	endtask

	task automatic random_item();
		logic [31:0] a, s;
		int m;
		m = $urandom_range(99);
		if (m < 45) begin
			// free near recently used space so regions touch and merge
			a = 32'($urandom_range(15)) << (4 + $urandom_range(3));
			s = 32'd16 << $urandom_range(2);
			if ($urandom_range(9) == 0) begin
				a = $urandom; s = $urandom;
			end
			send_item(fla_pkg::OpFree, a, s);
		end else if (m < 90) begin
			s = $urandom_range(9) == 0 ? $urandom : $urandom_range(80);
			send_item(fla_pkg::OpAlloc, $urandom, s);
		end else begin
			send_item(fla_pkg::OpFree, $urandom, $urandom_range(8));
		end
	endtask

	initial begin
		int k;
		int ph;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: empty table, zero sizes, extremes, merges, wrap
		send_item(fla_pkg::OpAlloc, 32'hFFFF_FFFF, 32'd0);
		send_item(fla_pkg::OpAlloc, 32'd0, 32'hFFFF_FFFF);
		send_item(fla_pkg::OpFree, 32'd100, 32'd0);
		send_item(fla_pkg::OpAlloc, 32'd0, 32'd0);
		send_item(fla_pkg::OpFree, 32'd0, 32'd64);
		send_item(fla_pkg::OpFree, 32'd128, 32'd64);
		send_item(fla_pkg::OpFree, 32'd64, 32'd64);
		send_item(fla_pkg::OpFree, 32'd512, 32'd16);
		send_item(fla_pkg::OpFree, 32'd496, 32'd16);
		send_item(fla_pkg::OpFree, 32'd528, 32'd8);
		send_item(fla_pkg::OpAlloc, 32'd0, 32'd0);
		send_item(fla_pkg::OpAlloc, 32'd0, 32'd10);
		send_item(fla_pkg::OpAlloc, 32'd0, 32'd182);
		send_item(fla_pkg::OpAlloc, 32'd0, 32'd1000);
		send_item(fla_pkg::OpFree, 32'hFFFF_FFF0, 32'h10);
		send_item(fla_pkg::OpFree, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(fla_pkg::OpFree, 32'h8000_0000, 32'h8000_0000);
		send_item(fla_pkg::OpAlloc, 32'd0, 32'h8000_0000);
		send_item(fla_pkg::OpFree, 32'd10, 32'd10);
		send_item(fla_pkg::OpAlloc, 32'd0, 32'd40);
		for (ph = 0; ph < 4; ph++) begin
			idle_pct = ph == 0 ? 0 : (ph == 1 ? 52 : (ph == 2 ? 0 : 29));
			for (k = 0; k < 20; k++) random_item();
		end
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d allocates and %0d frees, %0d results checked",
			n_alloc, n_free, board.checked);
		$display("peak table use %0d entries, %0d frees dropped",
			board.peak, board.lost_n);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#200ms;
		$display("FAIL");
		$finish;
	end
endmodule

/* free_list_allocator.f */
sv/fla_pkg.sv
sv/fla_ram.sv
sv/free_list_allocator.sv
sim/tb.sv
